[hw/rtl/bgss_pkg.sv]
// bgss_pkg: shared types, constants and decode functions of the battery gauge scanner
// used by the channel interfaces and every rtl module of the block

package bgss_pkg;

  localparam int unsigned NUM_DIGITS = 3;
  localparam int unsigned VOLT_W     = 10;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned LED_W      = 2;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned GLYPH_W    = 5;

  // apb register map
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;
  localparam logic [1:0]  REG_VOLT_END  = 2'd0;
  localparam logic [1:0]  REG_PCT_END   = 2'd1;
  localparam logic [1:0]  REG_CYCLE_END = 2'd2;
  localparam logic [CFG_W-1:0] RST_VOLT_END  = 8'd18;
  localparam logic [CFG_W-1:0] RST_PCT_END   = 8'd36;
  localparam logic [CFG_W-1:0] RST_CYCLE_END = 8'd186;

  // decoupling queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // glyph codes beyond the decimal digits
  localparam logic [GLYPH_W-1:0] GL_S         = 5'h10;
  localparam logic [GLYPH_W-1:0] GL_O         = 5'h11;
  localparam logic [GLYPH_W-1:0] GL_H         = 5'h12;
  localparam logic [GLYPH_W-1:0] GL_OVERLINE  = 5'h13;
  localparam logic [GLYPH_W-1:0] GL_UNDERLINE = 5'h14;
  localparam logic [GLYPH_W-1:0] GL_ONE_C     = 5'h15;

  // percent codes
  localparam logic [7:0] PCT_FULL = 8'd100;
  localparam logic [7:0] PCT_HIGH = 8'd254;
  localparam logic [7:0] PCT_SOS  = 8'd255;

  // led colors
  localparam logic [LED_W-1:0] LED_OFF   = 2'd0;
  localparam logic [LED_W-1:0] LED_RED   = 2'd1;
  localparam logic [LED_W-1:0] LED_GREEN = 2'd2;
  localparam logic [LED_W-1:0] LED_BOTH  = 2'd3;

  // digit pointer codes
  localparam logic [1:0] PTR_D1 = 2'd1;
  localparam logic [1:0] PTR_D2 = 2'd2;
  localparam logic [1:0] PTR_D3 = 2'd3;

  // one-hot digit selects
  localparam logic [NUM_DIGITS-1:0] SEL_D1   = 3'b001;
  localparam logic [NUM_DIGITS-1:0] SEL_D2   = 3'b010;
  localparam logic [NUM_DIGITS-1:0] SEL_D3   = 3'b100;
  localparam logic [NUM_DIGITS-1:0] SEL_NONE = 3'b000;

  typedef enum logic [1:0] {
    KIND_VOLT,
    KIND_PCT,
    KIND_BLANK,
    KIND_RESTART
  } kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] volt_end;
    logic [CFG_W-1:0] pct_end;
    logic [CFG_W-1:0] cycle_end;
  } cfg_t;

  // classified scan tick, glyphs already turned into segment patterns
  typedef struct packed {
    kind_e                            kind;
    logic [NUM_DIGITS-1:0][SEG_W-1:0] vseg;
    logic                             vovl;
    logic [NUM_DIGITS-1:0][SEG_W-1:0] pseg;
    logic                             pskip;
    logic [LED_W-1:0]                 led;
  } item_t;

  function automatic logic [SEG_W-1:0] glyph_seg(input logic [GLYPH_W-1:0] g);
    logic [SEG_W-1:0] s;
    unique case (g)
      5'h00:        s = 7'h3F;
      5'h01:        s = 7'h06;
      5'h02:        s = 7'h5B;
      5'h03:        s = 7'h4F;
      5'h04:        s = 7'h66;
      5'h05:        s = 7'h6D;
      5'h06:        s = 7'h7D;
      5'h07:        s = 7'h07;
      5'h08:        s = 7'h7F;
      5'h09:        s = 7'h6F;
      GL_S:         s = 7'h6D;
      GL_O:         s = 7'h5C;
      GL_H:         s = 7'h76;
      GL_OVERLINE:  s = 7'h01;
      GL_UNDERLINE: s = 7'h08;
      GL_ONE_C:     s = 7'h04;
      default:      s = 7'h00;
    endcase
    return s;
  endfunction

  // percent for voltages 11.3 V .. 12.7 V
  function automatic logic [7:0] pct_table(input logic [3:0] idx);
    logic [7:0] p;
    case (idx)
      4'd0, 4'd1, 4'd2: p = 8'd10;
      4'd3:             p = 8'd20;
      4'd4:             p = 8'd25;
      4'd5:             p = 8'd30;
      4'd6:             p = 8'd40;
      4'd7:             p = 8'd50;
      4'd8:             p = 8'd55;
      4'd9:             p = 8'd60;
      4'd10:            p = 8'd70;
      4'd11:            p = 8'd75;
      4'd12:            p = 8'd80;
      4'd13:            p = 8'd95;
      default:          p = 8'd100;
    endcase
    return p;
  endfunction

  // tens digit of a value below 100, reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] prod;
    prod = {8'b0, x} * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [6:0] rem;
    rem = x - {3'b0, div10(x)} * 7'd10;
    return rem[3:0];
  endfunction

endpackage

[hw/rtl/bgss_if.sv]
// bgss_in_if / bgss_out_if: valid-ready channels of the battery gauge scanner
// depends on bgss_pkg for field widths

interface bgss_in_if
  import bgss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] battery_voltage;
  logic              advance_phase;

  modport source (output valid, output battery_voltage, output advance_phase, input ready);
  modport sink   (input valid, input battery_voltage, input advance_phase, output ready);
endinterface

interface bgss_out_if
  import bgss_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [NUM_DIGITS-1:0] digit_select;
  logic [SEG_W-1:0]      segments;
  logic                  decimal_point;
  logic [LED_W-1:0]      led_color;
  logic                  measure_enable;

  modport source (output valid, output digit_select, output segments, output decimal_point,
                  output led_color, output measure_enable, input ready);
  modport sink   (input valid, input digit_select, input segments, input decimal_point,
                  input led_color, input measure_enable, output ready);
endinterface

[hw/rtl/bgss_regs.sv]
// bgss_regs: apb configuration registers of the battery gauge scanner
// depends on bgss_pkg for the register map and cfg_t

module bgss_regs
  import bgss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_VOLT_END:  cfg_d.volt_end  = pwdata[CFG_W-1:0];
        REG_PCT_END:   cfg_d.pct_end   = pwdata[CFG_W-1:0];
        REG_CYCLE_END: cfg_d.cycle_end = pwdata[CFG_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VOLT_END:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.volt_end};
      REG_PCT_END:   prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.pct_end};
      REG_CYCLE_END: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.cycle_end};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_end  <= RST_VOLT_END;
      cfg_q.pct_end   <= RST_PCT_END;
      cfg_q.cycle_end <= RST_CYCLE_END;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/bgss_queue.sv]
// bgss_queue: small fifo of classified scan ticks between front and back
// depends on bgss_pkg for item_t and the queue depth

module bgss_queue
  import bgss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  avail_o
);

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q, count_d;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign avail_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QAW+1)'(QDEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !avail_o))
    else $error("queue push when full or pop when empty");

endmodule

[hw/rtl/bgss_front.sv]
// bgss_front: accepts scan ticks, steps the phase counter and decodes the voltage
// depends on bgss_pkg and bgss_in_if; feeds bgss_queue

module bgss_front
  import bgss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  bgss_in_if.sink  in_i,
  input  cfg_t     cfg_i,
  input  logic     full_i,
  output logic     push_o,
  output item_t    item_o
);

  logic [CFG_W-1:0]   phase_q, phase_d, phase_inc;
  logic [VOLT_W-1:0]  v, rem_full;
  logic               hund;
  logic [6:0]         rem;
  logic [7:0]         pct;
  logic [3:0]         pct_idx;
  logic [VOLT_W-1:0]  pct_off;
  logic [NUM_DIGITS-1:0][GLYPH_W-1:0] vg, pg;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid & !full_i;
  assign v          = in_i.battery_voltage;

  // phase selection from the stepped count
  always_comb begin
    phase_inc = in_i.advance_phase ? phase_q + 1'b1 : phase_q;
    phase_d   = phase_inc;
    if (phase_inc < cfg_i.volt_end) begin
      item_o.kind = KIND_VOLT;
    end else if (phase_inc < cfg_i.pct_end) begin
      item_o.kind = KIND_PCT;
    end else if (phase_inc < cfg_i.cycle_end) begin
      item_o.kind = KIND_BLANK;
    end else begin
      item_o.kind = KIND_RESTART;
      phase_d     = '0;
    end
  end

  // voltage glyphs
  always_comb begin
    hund     = (v >= 10'd100);
    rem_full = v - (hund ? 10'd100 : 10'd0);
    rem      = rem_full[6:0];
    if (v > 10'd160) begin
      vg[0] = 5'd1;
      vg[1] = 5'd6;
      vg[2] = GL_OVERLINE;
    end else if (v <= 10'd89) begin
      vg[0] = GL_UNDERLINE;
      vg[1] = 5'd9;
      vg[2] = 5'd0;
    end else begin
      vg[0] = {4'b0, hund};
      vg[1] = {1'b0, div10(rem)};
      vg[2] = {1'b0, mod10(rem)};
    end
  end

  // percent code and its glyphs
  always_comb begin
    pct_off = v - 10'd113;
    pct_idx = pct_off[3:0];
    if (v >= 10'd150) begin
      pct = PCT_HIGH;
    end else if (v > 10'd127) begin
      pct = PCT_FULL;
    end else if (v < 10'd113) begin
      pct = PCT_SOS;
    end else begin
      pct = pct_table(pct_idx);
    end
    item_o.pskip = 1'b0;
    if (pct == PCT_FULL) begin
      pg[0] = 5'd1;
      pg[1] = 5'd0;
      pg[2] = 5'd0;
    end else if (pct == PCT_SOS) begin
      pg[0] = GL_S;
      pg[1] = GL_O;
      pg[2] = GL_S;
    end else if (pct == PCT_HIGH) begin
      pg[0]        = 5'd0;
      pg[1]        = GL_H;
      pg[2]        = GL_ONE_C;
      item_o.pskip = 1'b1;
    end else begin
      pg[0] = 5'd0;
      pg[1] = {1'b0, div10(pct[6:0])};
      pg[2] = {1'b0, mod10(pct[6:0])};
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      item_o.vseg[i] = glyph_seg(vg[i]);
      item_o.pseg[i] = glyph_seg(pg[i]);
    end
    item_o.vovl = (vg[2] == GL_OVERLINE);
    if (v > 10'd125) begin
      item_o.led = LED_GREEN;
    end else if (v >= 10'd124) begin
      item_o.led = LED_BOTH;
    end else begin
      item_o.led = LED_RED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (item_o.kind == KIND_RESTART) |=> (phase_q == '0))
    else $error("phase counter did not restart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_o |=> $stable(phase_q))
    else $error("phase counter moved without a transaction");

endmodule

[hw/rtl/bgss_back.sv]
// bgss_back: runs the digit scan on classified ticks and holds the display drive
// depends on bgss_pkg and bgss_out_if; fed by bgss_queue

module bgss_back
  import bgss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  item_t      item_i,
  output logic       pop_o,
  bgss_out_if.source out_o
);

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            vptr_q, vptr_d, pptr_q, pptr_d;
  logic [NUM_DIGITS-1:0] sel_q, sel_d;
  logic [SEG_W-1:0]      seg_q, seg_d;
  logic                  dp_q, dp_d, en_q, en_d;
  logic [LED_W-1:0]      led_q, led_d;

  assign pop_o = avail_i & (!out_valid_q | out_o.ready);

  always_comb begin
    vptr_d = vptr_q;
    pptr_d = pptr_q;
    sel_d  = sel_q;
    seg_d  = seg_q;
    dp_d   = dp_q;
    en_d   = en_q;
    led_d  = led_q;
    case (item_i.kind)
      KIND_VOLT: begin
        led_d  = item_i.led;
        pptr_d = PTR_D1;
        en_d   = 1'b0;
        case (vptr_q)
          PTR_D2: begin
            // point stays as it was when the last glyph is the overline
            dp_d   = item_i.vovl ? dp_q : 1'b1;
            sel_d  = SEL_D2;
            seg_d  = item_i.vseg[1];
            vptr_d = PTR_D3;
          end
          PTR_D3: begin
            dp_d   = 1'b0;
            sel_d  = SEL_D3;
            seg_d  = item_i.vseg[2];
            vptr_d = PTR_D1;
          end
          default: begin
            dp_d   = 1'b0;
            sel_d  = SEL_D1;
            seg_d  = item_i.vseg[0];
            vptr_d = PTR_D2;
          end
        endcase
      end
      KIND_PCT: begin
        led_d  = item_i.led;
        vptr_d = PTR_D1;
        case (pptr_q)
          PTR_D2: begin
            sel_d  = SEL_D2;
            seg_d  = item_i.pseg[1];
            pptr_d = PTR_D3;
          end
          PTR_D3: begin
            dp_d   = 1'b0;
            sel_d  = SEL_D3;
            seg_d  = item_i.pseg[2];
            pptr_d = PTR_D1;
          end
          default: begin
            pptr_d = PTR_D2;
            // h1 leaves the first digit as it was
            if (!item_i.pskip) begin
              dp_d  = 1'b0;
              sel_d = SEL_D1;
              seg_d = item_i.pseg[0];
            end
          end
        endcase
      end
      KIND_BLANK: begin
        en_d  = 1'b1;
        sel_d = SEL_NONE;
        dp_d  = 1'b0;
        led_d = LED_OFF;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      vptr_q      <= PTR_D1;
      pptr_q      <= PTR_D1;
      sel_q       <= SEL_NONE;
      seg_q       <= '0;
      dp_q        <= 1'b0;
      en_q        <= 1'b0;
      led_q       <= LED_OFF;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        vptr_q <= vptr_d;
        pptr_q <= pptr_d;
        sel_q  <= sel_d;
        seg_q  <= seg_d;
        dp_q   <= dp_d;
        en_q   <= en_d;
        led_q  <= led_d;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.digit_select   = sel_q;
  assign out_o.segments       = seg_q;
  assign out_o.decimal_point  = dp_q;
  assign out_o.led_color      = led_q;
  assign out_o.measure_enable = en_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_q) && (!dp_q || (sel_q == SEL_D2)))
    else $error("digit select not one-hot or point off digit 2");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && (item_i.kind == KIND_BLANK) |=>
      (sel_q == SEL_NONE) && (led_q == LED_OFF) && en_q)
    else $error("blank tick did not turn the display off");

endmodule

[hw/rtl/battery_gauge_seven_segment_scanner.sv]
// battery_gauge_seven_segment_scanner: top level of the battery gauge display scanner
// depends on bgss_pkg, bgss_if, bgss_regs, bgss_queue, bgss_front, bgss_back
// an accepted scan tick is written into the queue, then popped into the scan registers that
// drive the output; throughput: one scan tick per cycle while the receiver holds ready high,
// set by the single queue pop and scan-state update a cycle
// reset: asynchronous active low; phase count 0, digit pointers on digit 1, drive all zero,
// registers to 18 / 36 / 186; no clearing pass, ready as soon as reset is released

module battery_gauge_seven_segment_scanner
  import bgss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bgss_in_if.sink           in_i,
  bgss_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers, written by the user only while the scanner is idle; the block does not enforce it
  cfg_t  cfg;

  // front to queue
  logic  push;
  logic  full;
  item_t push_item;

  // queue to back
  logic  pop;
  logic  avail;
  item_t pop_item;

  bgss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: steps the phase count and classifies each tick as voltage,
  // percentage, blank or restart, with all glyphs pre-decoded to segments
  bgss_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // queue lets the phase counter run ahead while the display side stalls
  bgss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .avail_o (avail)
  );

  // back: digit pointers and held drive; the held drive is the output payload
  bgss_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .item_i  (pop_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[sim/bgss_tb_pkg.sv]
// bgss_tb_pkg: display predictor and result checker for the battery gauge scanner bench
// depends on bgss_pkg for widths, glyph, percent, led, pointer and select codes

package bgss_tb_pkg;
  import bgss_pkg::*;

  typedef struct packed {
    logic [NUM_DIGITS-1:0] sel;
    logic [SEG_W-1:0]      seg;
    logic                  dp;
    logic [LED_W-1:0]      led;
    logic                  men;
  } display_t;

  class gauge_predictor;
    logic [CFG_W-1:0]   volt_end, pct_end, cycle_end;
    logic [7:0]         phase;
    logic [1:0]         vptr, pptr;
    logic [7:0]         charge;
    logic [GLYPH_W-1:0] vglyph [NUM_DIGITS];
    display_t           held;
    display_t           expected_display[$];
    int unsigned        errors, checked;
    int unsigned        kind_count[4];

    function new();
      volt_end  = RST_VOLT_END;
      pct_end   = RST_PCT_END;
      cycle_end = RST_CYCLE_END;
      phase     = '0;
      vptr      = PTR_D1;
      pptr      = PTR_D1;
      charge    = '0;
      foreach (vglyph[i]) vglyph[i] = '0;
      held      = '0;
      errors    = 0;
      checked   = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_VOLT_END:  volt_end  = val;
        REG_PCT_END:   pct_end   = val;
        REG_CYCLE_END: cycle_end = val;
        default: ;
      endcase
    endfunction

    function logic [SEG_W-1:0] segs_of(logic [GLYPH_W-1:0] g);
      case (g)
        5'd0:         return 7'h3F;
        5'd1:         return 7'h06;
        5'd2:         return 7'h5B;
        5'd3:         return 7'h4F;
        5'd4:         return 7'h66;
        5'd5:         return 7'h6D;
        5'd6:         return 7'h7D;
        5'd7:         return 7'h07;
        5'd8:         return 7'h7F;
        5'd9:         return 7'h6F;
        GL_S:         return 7'h6D;
        GL_O:         return 7'h5C;
        GL_H:         return 7'h76;
        GL_OVERLINE:  return 7'h01;
        GL_UNDERLINE: return 7'h08;
        GL_ONE_C:     return 7'h04;
        default:      return 7'h00;
      endcase
    endfunction

    // charge percent inside the 11.3 V .. 12.7 V window
    function logic [7:0] charge_of(logic [VOLT_W-1:0] v);
      case (v)
        10'd113, 10'd114, 10'd115: return 8'd10;
        10'd116: return 8'd20;
        10'd117: return 8'd25;
        10'd118: return 8'd30;
        10'd119: return 8'd40;
        10'd120: return 8'd50;
        10'd121: return 8'd55;
        10'd122: return 8'd60;
        10'd123: return 8'd70;
        10'd124: return 8'd75;
        10'd125: return 8'd80;
        10'd126: return 8'd95;
        default: return PCT_FULL;
      endcase
    endfunction

    function void decode(logic [VOLT_W-1:0] v);
      int unsigned n;
      n = v;
      if (n >= 150)      charge = PCT_HIGH;
      else if (n > 127)  charge = PCT_FULL;
      else if (n < 113)  charge = PCT_SOS;
      else               charge = charge_of(v);
      if (n > 160) begin
        vglyph[0] = 5'd1;
        vglyph[1] = 5'd6;
        vglyph[2] = GL_OVERLINE;
      end else if (n <= 89) begin
        vglyph[0] = GL_UNDERLINE;
        vglyph[1] = 5'd9;
        vglyph[2] = 5'd0;
      end else begin
        vglyph[0] = GLYPH_W'(n / 100);
        vglyph[1] = GLYPH_W'((n % 100) / 10);
        vglyph[2] = GLYPH_W'(n % 10);
      end
      if (n > 125)       held.led = LED_GREEN;
      else if (n >= 124) held.led = LED_BOTH;
      else               held.led = LED_RED;
    endfunction

    // digit 2 keeps whatever point was held, the others clear it
    function void light(logic [GLYPH_W-1:0] g, logic [1:0] pos);
      if (pos != PTR_D2) held.dp = 1'b0;
      case (pos)
        PTR_D1:  held.sel = SEL_D1;
        PTR_D2:  held.sel = SEL_D2;
        default: held.sel = SEL_D3;
      endcase
      held.seg = segs_of(g);
    endfunction

    function void show_voltage();
      case (vptr)
        PTR_D2: begin
          if (vglyph[2] != GL_OVERLINE) held.dp = 1'b1;
          light(vglyph[1], PTR_D2);
          vptr = PTR_D3;
        end
        PTR_D3: begin
          light(vglyph[2], PTR_D3);
          vptr = PTR_D1;
        end
        default: begin
          light(vglyph[0], PTR_D1);
          vptr = PTR_D2;
        end
      endcase
    endfunction

    function void show_charge();
      logic [GLYPH_W-1:0] g;
      case (pptr)
        PTR_D2: begin
          if (charge == PCT_FULL)      g = 5'd0;
          else if (charge == PCT_SOS)  g = GL_O;
          else if (charge == PCT_HIGH) g = GL_H;
          else                         g = GLYPH_W'((charge % 100) / 10);
          light(g, PTR_D2);
          pptr = PTR_D3;
        end
        PTR_D3: begin
          if (charge == PCT_FULL)      g = 5'd0;
          else if (charge == PCT_SOS)  g = GL_S;
          else if (charge == PCT_HIGH) g = GL_ONE_C;
          else                         g = GLYPH_W'(charge % 10);
          light(g, PTR_D3);
          pptr = PTR_D1;
        end
        default: begin
          pptr = PTR_D2;
          if (charge != PCT_HIGH) begin
            if (charge == PCT_FULL)     g = 5'd1;
            else if (charge == PCT_SOS) g = GL_S;
            else                        g = 5'd0;
            light(g, PTR_D1);
          end
        end
      endcase
    endfunction

    function void note_scan_tick(logic [VOLT_W-1:0] v, logic adv);
      if (adv) phase = phase + 8'd1;
      if (phase < volt_end) begin
        decode(v);
        show_voltage();
        pptr     = PTR_D1;
        held.men = 1'b0;
        kind_count[KIND_VOLT]++;
      end else if (phase < pct_end) begin
        decode(v);
        show_charge();
        vptr = PTR_D1;
        kind_count[KIND_PCT]++;
      end else if (phase < cycle_end) begin
        held.men = 1'b1;
        held.sel = SEL_NONE;
        held.dp  = 1'b0;
        held.led = LED_OFF;
        kind_count[KIND_BLANK]++;
      end else begin
        phase = '0;
        kind_count[KIND_RESTART]++;
      end
      expected_display.push_back(held);
    endfunction

    function void check_display(display_t got);
      display_t want;
      if (expected_display.size() == 0) begin
        $error("display transaction with no scan tick pending");
        errors++;
        return;
      end
      want = expected_display.pop_front();
      checked++;
      if (got.sel !== want.sel) begin
        $error("digit_select: expected %0h, got %0h", want.sel, got.sel);
        errors++;
      end
      if (got.seg !== want.seg) begin
        $error("segments: expected %0h, got %0h", want.seg, got.seg);
        errors++;
      end
      if (got.dp !== want.dp) begin
        $error("decimal_point: expected %0h, got %0h", want.dp, got.dp);
        errors++;
      end
      if (got.led !== want.led) begin
        $error("led_color: expected %0h, got %0h", want.led, got.led);
        errors++;
      end
      if (got.men !== want.men) begin
        $error("measure_enable: expected %0h, got %0h", want.men, got.men);
        errors++;
      end
    endfunction
  endclass

endpackage

[sim/tb_battery_gauge_seven_segment_scanner.sv]
// tb_battery_gauge_seven_segment_scanner: self-checking bench of the battery gauge scanner
// depends on bgss_pkg, bgss_if, the scanner rtl and bgss_tb_pkg (predictor and checker)

module tb_battery_gauge_seven_segment_scanner;
  import bgss_pkg::*;
  import bgss_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VOLT_W-1:0] volts;
    logic              adv;
  } tick_t;

  // one register setting and how the traffic under it is shaped
  typedef struct {
    logic [CFG_W-1:0] volt_end;
    logic [CFG_W-1:0] pct_end;
    logic [CFG_W-1:0] cycle_end;
    int unsigned      adv_pct;
    int unsigned      idle_pct;
  } setting_t;

  localparam int unsigned TICKS_PER_SETTING = 82;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic              pready;

  // once set, neither side idles any more
  logic calm = 1'b0;

  gauge_predictor predictor;

  bgss_in_if  in_ch ();
  bgss_out_if out_ch ();

  battery_gauge_seven_segment_scanner i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // directed ticks under phase ends 2 / 5 / 7: voltage glyph extremes, overline,
  // underline, every charge band, h1 skip on the first digit, blank and restart
  tick_t directed_ticks [25] = '{
    '{10'd0,    1'b0}, '{10'd89,  1'b0}, '{10'd90,  1'b0}, '{10'd161, 1'b0},
    '{10'd160,  1'b0}, '{10'd1023, 1'b0},
    '{10'd99,   1'b1}, '{10'd100, 1'b0}, '{10'd124, 1'b0},
    '{10'd150,  1'b1}, '{10'd150, 1'b0}, '{10'd150, 1'b0}, '{10'd112, 1'b0},
    '{10'd113,  1'b0}, '{10'd127, 1'b0}, '{10'd128, 1'b0}, '{10'd149, 1'b0},
    '{10'd125,  1'b0},
    '{10'd126,  1'b1}, '{10'd123, 1'b1},
    '{10'd0,    1'b1}, '{10'd511, 1'b0}, '{10'd1,   1'b1},
    '{10'd512,  1'b1}, '{10'd1023, 1'b0}
  };

  // register settings for the random part: extremes, out of order phase ends,
  // the reset values, and a last one that runs without idling
  setting_t plan [8] = '{
    '{8'd8,   8'd16,  8'd40,  70, 25},
    '{8'd0,   8'd0,   8'd0,   50, 25},
    '{8'd255, 8'd255, 8'd255, 60, 0},
    '{8'd10,  8'd5,   8'd20,  70, 50},
    '{8'd18,  8'd36,  8'd186, 90, 25},
    '{8'd3,   8'd6,   8'd255, 80, 25},
    '{8'd0,   8'd200, 8'd210, 50, 50},
    '{8'd30,  8'd40,  8'd60,  80, 0}
  };

  // apb write followed by a read back of the same register
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    predictor.set_reg(idx, val);
    // back-to-back read: setup phase with psel kept high
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (rd !== APB_DW'(val)) begin
      $error("register %0d read back: expected %0d, got %0d", idx, val, rd);
      predictor.errors++;
    end
  endtask

  // present one scan tick and hold it until the transaction completes
  task automatic send_tick(input logic [VOLT_W-1:0] v, input logic adv);
    in_ch.valid           <= 1'b1;
    in_ch.battery_voltage <= v;
    in_ch.advance_phase   <= adv;
    do @(posedge clk_i); while (!in_ch.ready);
    predictor.note_scan_tick(v, adv);
  endtask

  // stop sending and wait until every expected display word has come back
  task automatic drain(input int unsigned tail);
    in_ch.valid <= 1'b0;
    while (predictor.expected_display.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // mostly the interesting 8.0 V .. 17.0 V span, some exact band edges,
  // and the rest spread over the full 10-bit range
  function automatic logic [VOLT_W-1:0] pick_voltage();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return VOLT_W'($urandom_range(0, 1023));
    if (r == 2) begin
      case ($urandom_range(0, 13))
        0:  return 10'd89;
        1:  return 10'd90;
        2:  return 10'd112;
        3:  return 10'd113;
        4:  return 10'd123;
        5:  return 10'd124;
        6:  return 10'd125;
        7:  return 10'd126;
        8:  return 10'd127;
        9:  return 10'd128;
        10: return 10'd149;
        11: return 10'd150;
        12: return 10'd160;
        default: return 10'd161;
      endcase
    end
    return VOLT_W'($urandom_range(80, 170));
  endfunction

  // result side: every completed display transaction is checked in order
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      predictor.check_display({out_ch.digit_select, out_ch.segments, out_ch.decimal_point,
                               out_ch.led_color, out_ch.measure_enable});
    end
  end

  // receiver backpressure: ready drops in random bursts until calm is set
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk_i);
        @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // hard stop in case a handshake never completes
  initial begin
    #2ms;
    $display("[battery_gauge_seven_segment_scanner] ERROR");
    $finish;
  end

  initial begin
    predictor             = new();
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.battery_voltage = '0;
    in_ch.advance_phase   = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: short phases so every phase shows up within a few ticks
    write_reg(REG_VOLT_END, 8'd2);
    write_reg(REG_PCT_END, 8'd5);
    write_reg(REG_CYCLE_END, 8'd7);
    foreach (directed_ticks[i]) send_tick(directed_ticks[i].volts, directed_ticks[i].adv);

    // random part, one register setting at a time, reprogrammed only when idle
    foreach (plan[s]) begin
      drain(4);
      write_reg(REG_CYCLE_END, plan[s].cycle_end);
      write_reg(REG_VOLT_END, plan[s].volt_end);
      write_reg(REG_PCT_END, plan[s].pct_end);
      if (s == $size(plan) - 1) calm = 1'b1;
      for (int unsigned n = 0; n < TICKS_PER_SETTING; n++) begin
        // random sender gaps between ticks
        if (!calm && $urandom_range(0, 99) < plan[s].idle_pct) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
        send_tick(pick_voltage(), $urandom_range(0, 99) < plan[s].adv_pct);
      end
    end

    // settle: leave room for any stray result
    drain(20);

    $display("scan ticks checked: %0d under %0d register settings", predictor.checked,
             $size(plan) + 1);
    $display("ticks by phase: voltage %0d, percent %0d, blank %0d, restart %0d",
             predictor.kind_count[KIND_VOLT], predictor.kind_count[KIND_PCT],
             predictor.kind_count[KIND_BLANK], predictor.kind_count[KIND_RESTART]);
    if (predictor.errors == 0) begin
      $display("[battery_gauge_seven_segment_scanner] OK");
    end else begin
      $display("[battery_gauge_seven_segment_scanner] ERROR");
    end
    $finish;
  end

endmodule
